FILE: sv/cac_pkg.sv
// Shared types, widths and constants for the correspondence adjacency check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cac_pkg;

    localparam int MAX_MATCHES_DEF = 64;

    localparam int COORD_W   = 24;
    localparam int PIX_W     = 16;
    localparam int REG_W     = 23;
    localparam int CFG_IDX_W = 8;
    localparam int SLOT_W    = 6;
    localparam int MASK_W    = 64;
    localparam int SQ_W      = 2 * COORD_W + 2;   // sum of three squares
    localparam int ROOT_W    = SQ_W / 2;          // one root bit per bit pair
    localparam int REM_W     = ROOT_W + 3;
    localparam int STEP_W    = $clog2(ROOT_W);
    localparam int DIST_W    = REG_W + 2;         // distances and thresholds
    localparam int PSUM_W    = 2 * PIX_W + 1;

    // 20 pixels in Q12.4, squared
    localparam logic [PSUM_W-1:0] PIX_LIMIT_SQ = PSUM_W'((20 * 16) * (20 * 16));

    localparam logic [CFG_IDX_W-1:0] REG_EXTENT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_ERR = CFG_IDX_W'(1);

    localparam int S_TDATA_W = 6 * COORD_W + 2 * PIX_W;   // 6 coords + 2 pixels = 176
    localparam int M_TDATA_W = 136;           // slot + two masks, padded

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // latch new match, clear masks
        logic rd_en;      // read stored match
        logic diff_en;    // register coordinate differences
        logic sq_en;      // register squares
        logic load_root;  // sum squares, start root units
        logic root_step;  // one root bit
        logic cmp_en;     // compare and set mask bit
        logic finish;     // load output register, store match
        logic drop;       // store was full
    } cac_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;   // result register still held
    } cac_stat_t;

endpackage

FILE: sv/cac_isqrt.sv
// Bit-serial truncating integer square root, one result bit per step.
// Depends on cac_pkg.
`timescale 1ns / 1ps
module cac_isqrt (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      step,
    input  logic [cac_pkg::SQ_W-1:0]  value,
    output logic [cac_pkg::ROOT_W-1:0] root
);
    import cac_pkg::*;

    logic [SQ_W-1:0]   val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // bring down next bit pair, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[SQ_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign root   = root_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (step) begin
            val_reg <= {val_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: sv/cac_ctrl.sv
// Controller: sequences the comparison of a new match against each stored match.
// Depends on cac_pkg.
`timescale 1ns / 1ps
module cac_ctrl #(
    parameter int MAX_MATCHES = cac_pkg::MAX_MATCHES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              first_of_set,
    input  cac_pkg::cac_stat_t                stat,
    output cac_pkg::cac_cmd_t                 cmd,
    output logic [$clog2(MAX_MATCHES)-1:0]    idx,
    output logic [$clog2(MAX_MATCHES)-1:0]    slot
);
    import cac_pkg::*;

    localparam int IDX_W = $clog2(MAX_MATCHES);
    localparam int CNT_W = $clog2(MAX_MATCHES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIFF, S_SQ, S_SUM, S_ROOT, S_CMP, S_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic              drop_reg;
    logic              accept;
    logic [CNT_W-1:0]  cnt_eff;
    logic              last_entry;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cnt_eff    = first_of_set ? '0 : cnt_reg;
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign idx        = idx_reg;
    assign slot       = cnt_reg[IDX_W-1:0];

    // command decode
    always_comb begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.rd_en     = (state_reg == S_READ);
        cmd.diff_en   = (state_reg == S_DIFF);
        cmd.sq_en     = (state_reg == S_SQ);
        cmd.load_root = (state_reg == S_SUM);
        cmd.root_step = (state_reg == S_ROOT);
        cmd.cmp_en    = (state_reg == S_CMP);
        cmd.finish    = (state_reg == S_DONE) && !stat.out_busy;
        cmd.drop      = drop_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            drop_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        cnt_reg  <= cnt_eff;
                        idx_reg  <= '0;
                        drop_reg <= (cnt_eff == CNT_W'(MAX_MATCHES));
                        if (cnt_eff == '0 || cnt_eff == CNT_W'(MAX_MATCHES)) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: state_reg <= S_DIFF;
                S_DIFF: state_reg <= S_SQ;
                S_SQ:   state_reg <= S_SUM;
                S_SUM: begin
                    step_reg  <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ROOT_W - 1)) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (last_entry) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE: begin
                    if (!stat.out_busy) begin
                        if (!drop_reg) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/cac_datapath.sv
// Datapath: match stores, distance arithmetic, threshold compares, result register.
// Depends on cac_pkg and cac_isqrt.
`timescale 1ns / 1ps
module cac_datapath #(
    parameter int MAX_MATCHES = cac_pkg::MAX_MATCHES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cac_pkg::cac_cmd_t                  cmd,
    output cac_pkg::cac_stat_t                 stat,
    input  logic [$clog2(MAX_MATCHES)-1:0]     idx,
    input  logic [$clog2(MAX_MATCHES)-1:0]     slot,
    input  logic [cac_pkg::S_TDATA_W-1:0]      in_data,
    input  logic                               cfg_we,
    input  logic [cac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cac_pkg::REG_W-1:0]          cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cac_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import cac_pkg::*;

    localparam int PT_W  = 3 * COORD_W;

    // configuration registers
    logic [REG_W-1:0] span_reg, err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg <= '0;
            err_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EXTENT:    span_reg <= cfg_data;
                REG_RANGE_ERR: err_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // new match
    logic [PT_W-1:0]    nq_reg, nt_reg;
    logic [2*PIX_W-1:0] np_reg;

    // stores
    logic [PT_W-1:0]    q_mem [MAX_MATCHES];
    logic [PT_W-1:0]    t_mem [MAX_MATCHES];
    logic [2*PIX_W-1:0] p_mem [MAX_MATCHES];
    logic [PT_W-1:0]    q_rd, t_rd;
    logic [2*PIX_W-1:0] p_rd;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            nq_reg <= in_data[PT_W-1:0];
            nt_reg <= in_data[2*PT_W-1:PT_W];
            np_reg <= in_data[2*PT_W +: 2*PIX_W];
        end
        if (cmd.rd_en) begin
            q_rd <= q_mem[idx];
            t_rd <= t_mem[idx];
            p_rd <= p_mem[idx];
        end
        if (cmd.finish && !cmd.drop) begin
            q_mem[slot] <= nq_reg;
            t_mem[slot] <= nt_reg;
            p_mem[slot] <= np_reg;
        end
    end

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] pix_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        pix_diff = (a > b) ? a - b : b - a;
    endfunction

    // absolute differences
    logic [COORD_W-1:0]   dq_reg [3];
    logic [COORD_W-1:0]   dt_reg [3];
    logic [PIX_W-1:0]     dp_reg [2];
    logic [2*COORD_W-1:0] sq_q_reg [3];
    logic [2*COORD_W-1:0] sq_t_reg [3];
    logic [2*PIX_W-1:0]   sq_p_reg [2];
    logic [PSUM_W-1:0]    psum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff_en) begin
            for (int k = 0; k < 3; k++) begin
                dq_reg[k] <= abs_diff(q_rd[k*COORD_W +: COORD_W], nq_reg[k*COORD_W +: COORD_W]);
                dt_reg[k] <= abs_diff(t_rd[k*COORD_W +: COORD_W], nt_reg[k*COORD_W +: COORD_W]);
            end
            for (int k = 0; k < 2; k++) begin
                dp_reg[k] <= pix_diff(p_rd[k*PIX_W +: PIX_W], np_reg[k*PIX_W +: PIX_W]);
            end
        end
        if (cmd.sq_en) begin
            for (int k = 0; k < 3; k++) begin
                sq_q_reg[k] <= dq_reg[k] * dq_reg[k];
                sq_t_reg[k] <= dt_reg[k] * dt_reg[k];
            end
            for (int k = 0; k < 2; k++) begin
                sq_p_reg[k] <= dp_reg[k] * dp_reg[k];
            end
        end
        if (cmd.load_root) begin
            psum_reg <= PSUM_W'(sq_p_reg[0]) + PSUM_W'(sq_p_reg[1]);
        end
    end

    // square roots of the summed squares
    logic [SQ_W-1:0]   sum_q, sum_t;
    logic [ROOT_W-1:0] root_q, root_t;

    assign sum_q = SQ_W'(sq_q_reg[0]) + SQ_W'(sq_q_reg[1]) + SQ_W'(sq_q_reg[2]);
    assign sum_t = SQ_W'(sq_t_reg[0]) + SQ_W'(sq_t_reg[1]) + SQ_W'(sq_t_reg[2]);

    cac_isqrt u_root_q (
        .aclk  (aclk),
        .load  (cmd.load_root),
        .step  (cmd.root_step),
        .value (sum_q),
        .root  (root_q)
    );

    cac_isqrt u_root_t (
        .aclk  (aclk),
        .load  (cmd.load_root),
        .step  (cmd.root_step),
        .value (sum_t),
        .root  (root_t)
    );

    // thresholds and compares
    logic [DIST_W-1:0] reach, tol4, tol2, diff;
    logic              phys_hit, samp_hit;

    assign reach    = DIST_W'(span_reg) + DIST_W'({err_reg, 1'b0});
    assign tol4     = {err_reg, 2'b00};
    assign tol2     = DIST_W'({err_reg, 1'b0});
    assign diff     = (root_t > root_q) ? DIST_W'(root_t - root_q) : DIST_W'(root_q - root_t);
    assign phys_hit = (DIST_W'(root_q) <= reach) && (diff <= tol4);
    assign samp_hit = phys_hit && (psum_reg > PIX_LIMIT_SQ) && (diff < tol2);

    // mask rows
    logic [MASK_W-1:0] phys_reg, samp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            phys_reg <= '0;
            samp_reg <= '0;
        end else if (cmd.cmp_en) begin
            phys_reg[idx] <= phys_hit;
            samp_reg[idx] <= samp_hit;
        end
    end

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_drop_reg <= cmd.drop;
            if (cmd.drop) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= M_TDATA_W'({samp_reg, phys_reg, SLOT_W'(slot)});
            end
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_drop_reg;
endmodule

FILE: sv/correspondence_adjacency_check.sv
// Top level of the correspondence adjacency check: controller plus datapath.
// Depends on cac_pkg, cac_ctrl, cac_datapath.
//
//  channel | direction | payload
//  s_      | in        | tuser: first_of_set; tdata: query xyz, train xyz, pixel xy
//  m_      | out       | tuser: dropped; tdata: match_slot, physical_mask, sample_mask
//  cfg_    | in        | index 0 object extent, 1 range error
//
// For each stored match before it, a new match costs one read, differences, squares,
// sums, 25 steps of the serial square root and a compare.
// A new match is taken only while the controller is idle; a finished result waits in
// the output register, and the next match may be taken while it waits.
// Reset (synchronous, aresetn low) empties the store count and clears both registers.
`timescale 1ns / 1ps
module correspondence_adjacency_check #(
    parameter int MAX_MATCHES = cac_pkg::MAX_MATCHES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [23:0] query_x, [47:24] query_y, [71:48] query_z, [95:72] train_x,
    // [119:96] train_y, [143:120] train_z, [159:144] pixel_x, [175:160] pixel_y
    input  logic [cac_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] first_of_set
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] match_slot, [69:6] physical_mask, [133:70] sample_mask, [135:134] zero
    output logic [cac_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] dropped
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cac_pkg::REG_W-1:0]       cfg_data
);
    import cac_pkg::*;

    localparam int IDX_W = $clog2(MAX_MATCHES);

    cac_cmd_t         cmd;
    cac_stat_t        stat;
    logic [IDX_W-1:0] idx, slot;

    assign cfg_ready = 1'b1;

    cac_ctrl #(.MAX_MATCHES(MAX_MATCHES)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .first_of_set (s_tuser),
        .stat         (stat),
        .cmd          (cmd),
        .idx          (idx),
        .slot         (slot)
    );

    cac_datapath #(.MAX_MATCHES(MAX_MATCHES)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .idx       (idx),
        .slot      (slot),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

FILE: sv/cac_checker.sv
// Port-level checks for the correspondence adjacency check, bound to the top level.
// Depends on cac_pkg and correspondence_adjacency_check.
`timescale 1ns / 1ps
module cac_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cac_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import cac_pkg::*;

    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] phys, samp;

    assign slot = m_tdata[SLOT_W-1:0];
    assign phys = m_tdata[SLOT_W +: MASK_W];
    assign samp = m_tdata[SLOT_W + MASK_W +: MASK_W];

    // a dropped match carries an empty result
    a_drop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("dropped result not empty");

    // sample adjacency implies physical adjacency
    a_samp_in_phys: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((samp & ~phys) == '0))
        else $error("sample bit without physical bit");

    // only earlier slots may be marked
    a_mask_below_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((phys >> slot) == '0))
        else $error("mask bit at or above own slot");

    // one match at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");
endmodule

bind correspondence_adjacency_check cac_checker u_cac_checker (.*);

FILE: test/tb_correspondence_adjacency_check.sv
// Self-checking bench for correspondence_adjacency_check: streams point matches,
// predicts both adjacency mask rows in a scoreboard class and checks every result.
// Depends on cac_pkg and the correspondence_adjacency_check RTL.
`timescale 1ns / 1ps

// Predicts the adjacency rows for accepted matches and checks the block's output
class adjacency_scoreboard;
    localparam int SLOTS = cac_pkg::MAX_MATCHES_DEF;

    typedef struct {
        logic [cac_pkg::SLOT_W-1:0] slot;
        logic [63:0]                phys;
        logic [63:0]                samp;
        logic                       dropped;
    } row_t;

    longint        q_mem[SLOTS][3];
    longint        t_mem[SLOTS][3];
    longint        px_mem[SLOTS];
    longint        py_mem[SLOTS];
    int            stored;
    longint        span;
    longint        err;
    row_t          pending_rows[$];
    int            errors;

    function new();
        stored = 0;
        span   = 0;
        err    = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [cac_pkg::CFG_IDX_W-1:0] idx, logic [cac_pkg::REG_W-1:0] val);
        if (idx == cac_pkg::REG_EXTENT)
            span = longint'(val);
        else if (idx == cac_pkg::REG_RANGE_ERR)
            err = longint'(val);
    endfunction

    // truncating integer square root
    function longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function longint unsigned span3(longint a0, longint a1, longint a2,
                                    longint b0, longint b1, longint b2);
        longint unsigned d0, d1, d2;
        d0 = (a0 > b0) ? a0 - b0 : b0 - a0;
        d1 = (a1 > b1) ? a1 - b1 : b1 - a1;
        d2 = (a2 > b2) ? a2 - b2 : b2 - a2;
        return int_root(d0 * d0 + d1 * d1 + d2 * d2);
    endfunction

    // Accepted input transfer: compute the expected row, then store the match
    function void note_match(logic first, logic [cac_pkg::S_TDATA_W-1:0] d);
        row_t            r;
        longint          q[3], t[3], px, py;
        longint unsigned dq, dt, diff, dx, dy;
        for (int k = 0; k < 3; k++) begin
            q[k] = longint'($signed(d[24*k +: 24]));
            t[k] = longint'($signed(d[72 + 24*k +: 24]));
        end
        px = longint'(d[159:144]);
        py = longint'(d[175:160]);
        if (first)
            stored = 0;
        r.slot = '0; r.phys = '0; r.samp = '0; r.dropped = 1'b0;
        if (stored >= SLOTS) begin
            r.dropped = 1'b1;
        end else begin
            r.slot = stored[cac_pkg::SLOT_W-1:0];
            for (int i = 0; i < stored; i++) begin
                dq = span3(q_mem[i][0], q_mem[i][1], q_mem[i][2], q[0], q[1], q[2]);
                if (dq > span + 2 * err)
                    continue;
                dt = span3(t_mem[i][0], t_mem[i][1], t_mem[i][2], t[0], t[1], t[2]);
                diff = (dt > dq) ? dt - dq : dq - dt;
                if (diff > 4 * err)
                    continue;
                r.phys[i] = 1'b1;
                dx = (px > px_mem[i]) ? px - px_mem[i] : px_mem[i] - px;
                dy = (py > py_mem[i]) ? py - py_mem[i] : py_mem[i] - py;
                if (dx * dx + dy * dy > 102400 && diff < 2 * err)
                    r.samp[i] = 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
                q_mem[stored][k] = q[k];
                t_mem[stored][k] = t[k];
            end
            px_mem[stored] = px;
            py_mem[stored] = py;
            stored++;
        end
        pending_rows.insert(pending_rows.size(), r);
    endfunction

    // Result transfer: compare against the oldest pending row
    function void check_result(logic [cac_pkg::M_TDATA_W-1:0] d, logic user);
        row_t r;
        if (pending_rows.size() == 0) begin
            $error("result with no pending row: tdata=%h tuser=%b", d, user);
            errors++;
            return;
        end
        r = pending_rows.pop_front();
        if (d[5:0] !== r.slot) begin
            $error("match_slot: expected %0d, actual %0d", r.slot, d[5:0]);
            errors++;
        end
        if (d[69:6] !== r.phys) begin
            $error("physical_mask: expected %h, actual %h", r.phys, d[69:6]);
            errors++;
        end
        if (d[133:70] !== r.samp) begin
            $error("sample_mask: expected %h, actual %h", r.samp, d[133:70]);
            errors++;
        end
        if (user !== r.dropped) begin
            $error("dropped: expected %b, actual %b", r.dropped, user);
            errors++;
        end
    endfunction
endclass

module tb_correspondence_adjacency_check;
    import cac_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_data;

    adjacency_scoreboard sb;
    bit                  gaps_on;
    int                  stall_left;

    // cluster state for well-formed sets
    longint base[3], shift[3], reach_lim, noise_lim;

    correspondence_adjacency_check uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // Result side: check each transfer, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                stall_left <= int'($urandom_range(1, 10));
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_match(input logic first, input logic [S_TDATA_W-1:0] d);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        sb.note_match(first, d);
    endtask

    // Stop sending and wait until every pending row has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [REG_W-1:0] span_v, input logic [REG_W-1:0] err_v);
        cfg_valid <= 1'b1;
        cfg_index <= REG_EXTENT;
        cfg_data  <= span_v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_EXTENT, span_v);
        cfg_index <= REG_RANGE_ERR;
        cfg_data  <= err_v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_RANGE_ERR, err_v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [S_TDATA_W-1:0] pack(longint q[3], longint t[3],
                                                   logic [15:0] px, logic [15:0] py);
        logic [S_TDATA_W-1:0] d;
        for (int k = 0; k < 3; k++) begin
            d[24*k +: 24]      = q[k][23:0];
            d[72 + 24*k +: 24] = t[k][23:0];
        end
        d[159:144] = px;
        d[175:160] = py;
        return d;
    endfunction

    function automatic longint rand_coord();
        return longint'($signed(24'($urandom())));
    endfunction

    function automatic longint sym(longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Fully random match, every bit free
    function automatic logic [S_TDATA_W-1:0] noise_match();
        longint q[3], t[3];
        for (int k = 0; k < 3; k++) begin
            q[k] = rand_coord();
            t[k] = rand_coord();
        end
        return pack(q, t, 16'($urandom()), 16'($urandom()));
    endfunction

    // Match from the current rigid cluster: train follows query plus small noise
    function automatic logic [S_TDATA_W-1:0] cluster_match();
        longint q[3], t[3];
        for (int k = 0; k < 3; k++) begin
            q[k] = base[k] + sym(reach_lim);
            t[k] = q[k] + shift[k] + sym(noise_lim);
        end
        return pack(q, t, 16'($urandom()), 16'($urandom()));
    endfunction

    task automatic new_cluster();
        for (int k = 0; k < 3; k++) begin
            base[k]  = sym(3000000);
            shift[k] = sym(3000000);
        end
    endtask

    initial begin
        #400_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        longint q[3], t[3];
        logic [REG_W-1:0] span_v, err_v;
        int len, sent;

        sb         = new();
        gaps_on    = 1'b1;
        stall_left = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero registers, identical points are adjacent at zero distance
        for (int k = 0; k < 3; k++) begin q[k] = 0; t[k] = 0; end
        send_match(1'b1, pack(q, t, 16'd0, 16'd0));
        send_match(1'b0, pack(q, t, 16'hFFFF, 16'hFFFF));
        for (int k = 0; k < 3; k++) begin q[k] = -8388608; t[k] = 8388607; end
        send_match(1'b0, pack(q, t, 16'd0, 16'hFFFF));
        drain();

        // Directed: both registers at maximum, coordinate extremes
        write_regs(23'h7FFFFF, 23'h7FFFFF);
        for (int k = 0; k < 3; k++) begin q[k] = 8388607; t[k] = -8388608; end
        send_match(1'b1, pack(q, t, 16'hFFFF, 16'd0));
        for (int k = 0; k < 3; k++) begin q[k] = -8388608; t[k] = 8388607; end
        send_match(1'b0, pack(q, t, 16'd0, 16'hFFFF));
        for (int k = 0; k < 3; k++) begin q[k] = 0; t[k] = 0; end
        send_match(1'b0, pack(q, t, 16'd320, 16'd0));
        send_match(1'b0, pack(q, t, 16'd0, 16'd0));
        send_match(1'b0, pack(q, t, 16'd321, 16'd0));
        drain();

        // Directed: fill the store, then overflow, then restart the set
        write_regs(23'd200000, 23'd3000);
        reach_lim = 100000; noise_lim = 1500;
        new_cluster();
        for (int i = 0; i < 66; i++)
            send_match(i == 0, cluster_match());
        send_match(1'b1, cluster_match());
        drain();

        // Random phases, register settings changed between phases
        sent = 0;
        for (int phase = 0; sent < 880; phase++) begin
            case (phase % 5)
                0: begin span_v = '0; err_v = '0; end
                1: begin span_v = 23'h7FFFFF; err_v = 23'h7FFFFF; end
                default: begin
                    span_v = REG_W'($urandom_range(0, 400000));
                    err_v  = REG_W'($urandom_range(0, 8000));
                end
            endcase
            write_regs(span_v, err_v);
            reach_lim = (span_v > 2000000) ? 2000000 : longint'(span_v) / 2;
            noise_lim = (err_v > 20000) ? 20000 : longint'(err_v);
            for (int s = 0; s < 12 && sent < 880; s++) begin
                len = ($urandom_range(0, 39) == 0) ? 67 : int'($urandom_range(1, 12));
                new_cluster();
                if (sent > 780)
                    gaps_on = 1'b0;
                for (int i = 0; i < len; i++) begin
                    // mostly coherent clusters; some noise and a rare stray restart
                    if ($urandom_range(0, 3) == 0)
                        send_match(i == 0 || $urandom_range(0, 30) == 0, noise_match());
                    else
                        send_match(i == 0, cluster_match());
                    sent++;
                end
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/cac_pkg.sv
sv/cac_isqrt.sv
sv/cac_ctrl.sv
sv/cac_datapath.sv
sv/correspondence_adjacency_check.sv
sv/cac_checker.sv
test/tb_correspondence_adjacency_check.sv
